### rtl/qsud_pkg.sv
package qsud_pkg;

	// Input opcodes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_ARG_END = 2'd1;
	localparam logic [1:0] KIND_STR_END = 2'd2;

	// Characters with a special meaning in a query string.
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// Most results one request can cause.
	localparam int MAX_RESULTS = 4;

	// Default depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_out;
	} res_t;

	// One classified request: up to four results and how many are used.
	typedef struct packed {
		logic [2:0]             count;
		res_t [MAX_RESULTS-1:0] res;
	} cmd_t;

	// Queue status seen by the front.
	typedef struct packed {
		logic full;
	} qstat_t;

	// Head of the queue seen by the back.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

endpackage

### rtl/qsud_if.sv
interface qsud_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] char_in;

	modport source (output valid, output opcode, output char_in, input ready);
	modport sink (input valid, input opcode, input char_in, output ready);
endinterface

interface qsud_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic       run_last;

	modport source (output valid, output kind, output char_out, output run_last, input ready);
	modport sink (input valid, input kind, input char_out, input run_last, output ready);
endinterface

### rtl/qsud_front.sv
module qsud_front
	import qsud_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic       opcode,
	input  logic [7:0] char_in,
	input  qstat_t     qstat,
	output logic       push,
	output cmd_t       cmd
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	logic [1:0] phase_q;
	logic [7:0] held_q;
	logic       open_q;
	logic [1:0] phase_d;
	logic [7:0] held_d;
	logic       open_d;
	logic       accept;
	logic       c_hex;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	// Nibble value of a hex digit; only meaningful when is_hex holds.
	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [7:0] v;
		if (c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c <= 8'h46) begin
			v = c - 8'h37;
		end else begin
			v = c - 8'h57;
		end
		hex_nib = v[3:0];
	endfunction

	function automatic cmd_t append(input cmd_t c, input logic [1:0] k, input logic [7:0] ch);
		cmd_t r;
		r = c;
		r.res[c.count[1:0]].kind = k;
		r.res[c.count[1:0]].char_out = ch;
		r.count = c.count + 3'd1;
		append = r;
	endfunction

	assign ready  = !qstat.full;
	assign accept = valid && ready;
	assign c_hex  = is_hex(char_in);
	assign push   = accept && (cmd.count != 3'd0);

	always_comb begin
		cmd     = '0;
		phase_d = phase_q;
		held_d  = held_q;
		open_d  = open_q;
		if (opcode == OP_END || !(((phase_q == PH_PCT) || (phase_q == PH_DIGIT)) && c_hex)) begin
			// Whatever is held goes out literally first.
			if (phase_q == PH_PCT || phase_q == PH_DIGIT) begin
				cmd = append(cmd, KIND_BYTE, CH_PERCENT);
			end
			if (phase_q == PH_DIGIT) begin
				cmd = append(cmd, KIND_BYTE, held_q);
			end
			phase_d = PH_IDLE;
			held_d  = '0;
			if (opcode == OP_END) begin
				if (open_q) begin
					cmd = append(cmd, KIND_ARG_END, 8'h00);
				end
				cmd    = append(cmd, KIND_STR_END, 8'h00);
				open_d = 1'b0;
			end else if (char_in == CH_AMP) begin
				cmd    = append(cmd, KIND_ARG_END, 8'h00);
				open_d = 1'b0;
			end else begin
				open_d = 1'b1;
				if (char_in == CH_PLUS) begin
					cmd = append(cmd, KIND_BYTE, CH_SPACE);
				end else if (char_in == CH_PERCENT) begin
					phase_d = PH_PCT;
				end else begin
					cmd = append(cmd, KIND_BYTE, char_in);
				end
			end
		end else if (phase_q == PH_PCT) begin
			held_d  = char_in;
			phase_d = PH_DIGIT;
		end else begin
			cmd     = append(cmd, KIND_BYTE, {hex_nib(held_q), hex_nib(char_in)});
			phase_d = PH_IDLE;
			held_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
			open_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			open_q  <= open_d;
		end
	end

endmodule

### rtl/qsud_fifo.sv
module qsud_fifo
	import qsud_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   wr_cmd,
	input  logic   pop,
	output qstat_t qstat,
	output qhead_t qhead
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cmd_t          store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign qstat.full = (cnt_q == FULL_CNT);
	assign qhead.valid = (cnt_q != '0);
	assign qhead.cmd = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

### rtl/qsud_back.sv
module qsud_back
	import qsud_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  qhead_t     qhead,
	output logic       pop,
	output logic       valid,
	input  logic       ready,
	output logic [1:0] kind,
	output logic [7:0] char_out,
	output logic       run_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] char_q;
	logic       last_q;
	logic       load;
	logic       last;

	assign load = qhead.valid && (!valid_q || ready);
	assign last = ({1'b0, idx_q} + 3'd1) == qhead.cmd.count;
	assign pop  = load && last;

	assign valid    = valid_q;
	assign kind     = kind_q;
	assign char_out = char_q;
	assign run_last = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= qhead.cmd.res[idx_q].kind;
			char_q <= qhead.cmd.res[idx_q].char_out;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/query_string_url_decoder.sv
// Query string URL decoder. Each request carries one byte of a query string
// (opcode 0) or marks the end of the string (opcode 1). The block answers with
// a stream of results: decoded bytes, end-of-argument marks for every '&', and
// one end-of-string mark. '+' decodes to a space and "%hh" with hex digits of
// either case decodes to one byte; a broken escape passes through literally.
// Every result carries run_last on the last result caused by its request.
// Rate: one request is taken per cycle while the command queue is not full,
// and the back end emits one result per cycle while the output is ready. The
// first result of a request is written to the queue, then to the output
// register. The command queue between the front and back end holds QDEPTH
// classified requests, so the input keeps flowing while the output is stalled
// until that queue fills.
module query_string_url_decoder
	import qsud_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	qsud_req_if.sink   req,
	qsud_res_if.source res
);

	qstat_t qstat;
	qhead_t qhead;
	cmd_t   cmd;
	logic   push;
	logic   pop;

	// The front end decodes each request against the escape state and turns it
	// into one command listing all of its results; requests that only advance
	// an escape produce no command.
	qsud_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (req.valid),
		.ready   (req.ready),
		.opcode  (req.opcode),
		.char_in (req.char_in),
		.qstat   (qstat),
		.push    (push),
		.cmd     (cmd)
	);

	// The queue decouples the two ends so each can stall on its own.
	qsud_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.pop    (pop),
		.qstat  (qstat),
		.qhead  (qhead)
	);

	// The back end walks through the results of the head command into a
	// registered output stage.
	qsud_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qhead    (qhead),
		.pop      (pop),
		.valid    (res.valid),
		.ready    (res.ready),
		.kind     (res.kind),
		.char_out (res.char_out),
		.run_last (res.run_last)
	);

endmodule

### rtl/qsud_checker.sv
module qsud_checker
	import qsud_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic [7:0] res_char_out,
	input logic       res_run_last
);

	// A stalled result stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
		$stable(res_char_out) && $stable(res_run_last))
		else $error("result changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_kind == KIND_BYTE || res_kind == KIND_ARG_END ||
		res_kind == KIND_STR_END))
		else $error("illegal result kind");

	a_marks_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_BYTE |-> res_char_out == 8'h00)
		else $error("mark result carries a nonzero byte");

	// The end of string is always the final result of its request.
	a_str_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_STR_END |-> res_run_last)
		else $error("end of string not last result of its request");

endmodule

bind query_string_url_decoder qsud_checker u_qsud_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_kind     (res.kind),
	.res_char_out (res.char_out),
	.res_run_last (res.run_last)
);

### bench/query_string_url_decoder_tb.sv
module query_string_url_decoder_tb;
	import qsud_pkg::*;

	// Cycles without any accepted request or result before the run is declared hung.
	// The longest legitimate quiet stretch is the output hold-off.
	localparam int IDLE_LIMIT = 2000;

	// The first result of a request passes the command queue and the output
	// register. These cycles let any stray result show up before the verdict.
	localparam int DRAIN_CYCLES = 20;

	// How the result side drives ready.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_e;

	typedef struct {
		logic [1:0] kind;
		logic [7:0] char_out;
		logic       run_last;
	} decoded_t;

	logic clk;
	logic arst_n;

	qsud_req_if req_ch ();
	qsud_res_if res_ch ();

	query_string_url_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decoder state as the predictor tracks it. The escape phase counts how much
	// of a "%hh" sequence is being held back: 0 none, 1 the '%', 2 '%' and a digit.
	logic [1:0] escape_phase;
	logic [7:0] held_digit;
	logic       argument_open;

	// Results of the request being predicted, then the queue of results that the
	// block still owes, oldest first.
	decoded_t step_results[$];
	decoded_t pending_decoded[$];
	decoded_t oldest;

	int error_count;
	int requests_sent;
	int results_checked;
	int idle_cycles;

	// Sender burst control and receiver stall control.
	logic     sender_gaps;
	int       burst_left;
	rx_mode_e rx_mode;
	int       rx_phase;
	int       hold_left;

	// Value of a hex digit of either case, or -1 when the byte is not one.
	function automatic int hex_value(logic [7:0] c);
		int v;
		v = c;
		if (c >= "0" && c <= "9") return v - 48;
		if (c >= "A" && c <= "F") return v - 55;
		if (c >= "a" && c <= "f") return v - 87;
		return -1;
	endfunction

	function automatic void add_result(logic [1:0] k, logic [7:0] ch);
		decoded_t r;
		r.kind     = k;
		r.char_out = ch;
		r.run_last = 1'b0;
		step_results.push_back(r);
	endfunction

	// A held '%' and digit that turn out not to be an escape go out as they came.
	function automatic void release_held();
		if (escape_phase == 2'd1) begin
			add_result(KIND_BYTE, CH_PERCENT);
		end else if (escape_phase == 2'd2) begin
			add_result(KIND_BYTE, CH_PERCENT);
			add_result(KIND_BYTE, held_digit);
		end
		escape_phase = 2'd0;
		held_digit   = 8'h00;
	endfunction

	// A byte seen outside any escape: '&' closes the argument, '+' is a space and
	// '%' opens an escape. Anything else, zero included, is literal.
	function automatic void plain_char(logic [7:0] c);
		if (c == CH_AMP) begin
			add_result(KIND_ARG_END, 8'h00);
			argument_open = 1'b0;
			return;
		end
		argument_open = 1'b1;
		if (c == CH_PLUS) begin
			add_result(KIND_BYTE, CH_SPACE);
		end else if (c == CH_PERCENT) begin
			escape_phase = 2'd1;
		end else begin
			add_result(KIND_BYTE, c);
		end
	endfunction

	// Works out what one accepted request must produce and queues it.
	function automatic void url_decode_step(logic op, logic [7:0] c);
		int lo;
		int hi;
		step_results.delete();
		lo = hex_value(c);
		if (op == OP_END) begin
			// The end of the string flushes, closes an open argument and marks the end.
			release_held();
			if (argument_open) add_result(KIND_ARG_END, 8'h00);
			add_result(KIND_STR_END, 8'h00);
			argument_open = 1'b0;
		end else if (escape_phase == 2'd1) begin
			if (lo >= 0) begin
				held_digit   = c;
				escape_phase = 2'd2;
			end else begin
				release_held();
				plain_char(c);
			end
		end else if (escape_phase == 2'd2) begin
			if (lo >= 0) begin
				hi = hex_value(held_digit);
				add_result(KIND_BYTE, 8'(hi * 16 + lo));
				escape_phase = 2'd0;
				held_digit   = 8'h00;
			end else begin
				release_held();
				plain_char(c);
			end
		end else begin
			escape_phase = 2'd0;
			plain_char(c);
		end
		if (step_results.size() > 0) step_results[step_results.size() - 1].run_last = 1'b1;
		foreach (step_results[i]) pending_decoded.push_back(step_results[i]);
	endfunction

	// Both channels are observed at the rising edge. A request is predicted before
	// the result of the same edge is checked, which keeps the queue in order even if
	// a result could leave in the cycle its request arrives.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				url_decode_step(req_ch.opcode, req_ch.char_in);
			end
			if (res_ch.valid && res_ch.ready) begin
				results_checked++;
				if (pending_decoded.size() == 0) begin
					$error("unexpected result: kind %0d, char_out %02h, run_last %0d",
						res_ch.kind, res_ch.char_out, res_ch.run_last);
					error_count++;
				end else begin
					oldest = pending_decoded.pop_front();
					if (res_ch.kind !== oldest.kind) begin
						$error("kind: expected %0d, actual %0d", oldest.kind, res_ch.kind);
						error_count++;
					end
					if (res_ch.char_out !== oldest.char_out) begin
						$error("char_out: expected %02h, actual %02h",
							oldest.char_out, res_ch.char_out);
						error_count++;
					end
					if (res_ch.run_last !== oldest.run_last) begin
						$error("run_last: expected %0d, actual %0d",
							oldest.run_last, res_ch.run_last);
						error_count++;
					end
				end
			end
			// The watchdog only counts cycles in which neither side moves anything.
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: nothing moved for %0d cycles.", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// The result side. A hold-off set by a test wins over everything else; otherwise
	// ready follows the current mode: always high, random, or a fixed repeating
	// pattern with stalled cycles in it.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				res_ch.ready = 1'b0;
				hold_left--;
			end else begin
				case (rx_mode)
					RX_ALWAYS: res_ch.ready = 1'b1;
					RX_RANDOM: res_ch.ready = ($urandom_range(0, 99) >= 35);
					default: begin
						res_ch.ready = !(rx_phase == 2 || rx_phase == 3 || rx_phase == 5);
						rx_phase = (rx_phase + 1) % 7;
					end
				endcase
			end
		end
	end

	// Offers one request and returns once the block has taken it. With gaps enabled
	// the sender works in bursts and may drop valid between them.
	task automatic send_request(logic op, logic [7:0] c);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = 0;
			if (sender_gaps && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		req_ch.valid   = 1'b1;
		req_ch.opcode  = op;
		req_ch.char_in = c;
		do @(posedge clk); while (!req_ch.ready);
		requests_sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		send_request(OP_BYTE, c);
	endtask

	// The end request carries a junk byte, which the block must ignore.
	task automatic send_end();
		send_request(OP_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_char(s[i]);
	endtask

	function automatic logic [7:0] random_hex_digit();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	// Bytes that end an escape: the neighbors of the hex ranges, the special
	// characters, or now and then any byte at all.
	function automatic logic [7:0] random_breaker();
		string near_misses;
		near_misses = "/:@G`g&+%";
		if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
		return near_misses[$urandom_range(0, near_misses.len() - 1)];
	endfunction

	// An end request with nothing before it gives only the end of string.
	task automatic test_empty_string();
		send_end();
	endtask

	// Byte extremes, the '+' to space rule, and an argument closed by the end.
	task automatic test_literal_bytes();
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CH_PLUS);
		send_char(8'h7F);
		send_end();
	endtask

	// Well-formed escapes with digits, lowercase and mixed case.
	task automatic test_hex_escapes();
		send_text("%41%aF");
		send_end();
	endtask

	// Broken escapes: a non-hex byte after '%', a '%' that breaks a held digit and
	// then starts its own escape, '&' after an escape, and an end request that finds
	// '%' and a digit still held, which gives the most results of any request.
	task automatic test_broken_escapes();
		send_text("%G%4%41&%4");
		send_end();
	endtask

	// The receiver stops for a long stretch while the sender keeps going, so the
	// internal queue fills and the block has to stall its request side.
	task automatic test_output_backpressure();
		sender_gaps = 1'b0;
		rx_mode     = RX_ALWAYS;
		@(negedge clk);
		req_ch.valid = 1'b0;
		hold_left    = 80;
		repeat (20) send_char(8'($urandom_range(8'h30, 8'h7A)));
		send_text("%3c+%%7e");
		send_end();
	endtask

	// Random query strings, mostly well formed: escapes, text, '+' and '&', with
	// broken escapes and arbitrary bytes mixed in. Every string ends with an end.
	task automatic test_random_strings(int item_count, logic gaps, rx_mode_e mode);
		int sent;
		int pieces;
		sender_gaps = gaps;
		rx_mode     = mode;
		sent        = 0;
		while (sent < item_count) begin
			pieces = $urandom_range(0, 7);
			repeat (pieces) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						send_char(CH_PERCENT);
						send_char(random_hex_digit());
						send_char(random_hex_digit());
						sent += 3;
					end
					4: begin
						send_char(8'($urandom_range(8'h21, 8'h7E)));
						sent++;
					end
					5: begin
						send_char(CH_PLUS);
						sent++;
					end
					6: begin
						send_char(CH_AMP);
						sent++;
					end
					7: begin
						send_char(8'($urandom_range(0, 255)));
						sent++;
					end
					8: begin
						send_char(CH_PERCENT);
						sent++;
						if ($urandom_range(0, 1)) begin
							send_char(random_hex_digit());
							sent++;
						end
						send_char(random_breaker());
						sent++;
					end
					default: begin
						send_char(random_breaker());
						sent++;
					end
				endcase
			end
			send_end();
			sent++;
		end
	endtask

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.opcode   = OP_BYTE;
		req_ch.char_in  = 8'h00;
		res_ch.ready    = 1'b0;
		escape_phase    = 2'd0;
		held_digit      = 8'h00;
		argument_open   = 1'b0;
		error_count     = 0;
		requests_sent   = 0;
		results_checked = 0;
		idle_cycles     = 0;
		sender_gaps     = 1'b1;
		burst_left      = 0;
		rx_mode         = RX_RANDOM;
		rx_phase        = 0;
		hold_left       = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_string();
		test_literal_bytes();
		test_hex_escapes();
		test_broken_escapes();
		test_output_backpressure();
		test_random_strings(55, 1'b1, RX_RANDOM);
		test_random_strings(35, 1'b0, RX_ALWAYS);
		test_random_strings(55, 1'b1, RX_PATTERN);

		@(negedge clk);
		req_ch.valid = 1'b0;
		rx_mode      = RX_RANDOM;
		while (pending_decoded.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_decoded.size() != 0) begin
			$error("%0d results never arrived", pending_decoded.size());
			error_count++;
		end
		$display("Sent %0d requests and checked %0d results from them.",
			requests_sent, results_checked);
		$display("Covered escapes, broken escapes, '+', '&', end flushes and a full output stall.");
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/qsud_pkg.sv
rtl/qsud_if.sv
rtl/qsud_front.sv
rtl/qsud_fifo.sv
rtl/qsud_back.sv
rtl/query_string_url_decoder.sv
rtl/qsud_checker.sv
bench/query_string_url_decoder_tb.sv
